FILE: design/circular_fifo_queue_top_assert.svh
// Assertion macros for the circular FIFO queue checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef CIRCULAR_FIFO_QUEUE_TOP_ASSERT_SVH
`define CIRCULAR_FIFO_QUEUE_TOP_ASSERT_SVH

// ante holds in this cycle, so cons holds in the same cycle
`define CFQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfq assertion failed");

// ante holds in this cycle, so cons holds in the next one
`define CFQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfq assertion failed");

`endif

FILE: design/cfq_pkg.sv
// Shared types, codes and helpers for the circular FIFO queue.
// No dependencies.
package cfq_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned WORD_W = 32;

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [WORD_W-1:0]  word_t;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_DISP = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic  wr_en;
    logic  rd_en;
    idx_t  addr;
    word_t wdata;
  } ram_req_t;

  typedef struct packed {
    logic    load;
    status_e status;
    logic    use_ram;
    logic    last;
    logic    is_empty;
    logic    is_full;
  } res_t;

  function automatic idx_t next_idx(idx_t i);
    next_idx = (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
  endfunction

endpackage

FILE: design/cfq_ram.sv
// Single-port entry store with registered read data.
// Depends on cfq_pkg.
module cfq_ram import cfq_pkg::*; (
  input  logic     clk_i,
  input  ram_req_t req_i,
  output word_t    rdata_o
);

  word_t mem_q [DEPTH];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/cfq_ctrl.sv
// Head/tail pointers, empty flag and the operation sequencer.
// Depends on cfq_pkg; drives cfq_ram and the result register.
module cfq_ctrl import cfq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  opcode_e  opcode_i,
  input  word_t    data_in_i,
  input  logic     out_free_i,
  output logic     in_ready_o,
  output ram_req_t ram_req_o,
  output res_t     res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DISP = 2'd2;

  logic [1:0] state_q, state_d;
  idx_t       head_q, head_d;
  idx_t       tail_q, tail_d;
  idx_t       cur_q, cur_d;
  logic       empty_q, empty_d;
  logic       full_now, accept, fin;

  assign full_now   = !empty_q && (next_idx(tail_q) == head_q);
  assign in_ready_o = (state_q == S_IDLE) && out_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign fin        = (cur_q == tail_q);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cur_d     = cur_q;
    empty_d   = empty_q;
    ram_req_o = '{wr_en: 1'b0, rd_en: 1'b0, addr: head_q, wdata: data_in_i};
    res_o     = '{load: 1'b0, status: ST_OK, use_ram: 1'b0, last: 1'b1,
                  is_empty: empty_q, is_full: full_now};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_ENQ) begin
            res_o.load = 1'b1;
            if (full_now) begin
              res_o.status = ST_FULL;
            end else begin
              if (empty_q) begin
                head_d  = '0;
                tail_d  = '0;
                empty_d = 1'b0;
              end else begin
                tail_d = next_idx(tail_q);
              end
              ram_req_o.wr_en = 1'b1;
              ram_req_o.addr  = tail_d;
            end
            res_o.is_empty = empty_d;
            res_o.is_full  = !empty_d && (next_idx(tail_d) == head_d);
          end else if (empty_q) begin
            res_o.load   = 1'b1;
            res_o.status = ST_EMPTY;
          end else begin
            ram_req_o.rd_en = 1'b1;
            cur_d           = head_q;
            state_d         = (opcode_i == OP_DISP) ? S_DISP : S_READ;
            if (opcode_i == OP_DEQ) begin
              if (head_q == tail_q) begin
                empty_d = 1'b1;
                head_d  = '0;
                tail_d  = '0;
              end else begin
                head_d = next_idx(head_q);
              end
            end
          end
        end
      end
      S_READ: begin
        if (out_free_i) begin
          res_o.load    = 1'b1;
          res_o.use_ram = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_DISP: begin
        if (out_free_i) begin
          res_o.load    = 1'b1;
          res_o.use_ram = 1'b1;
          res_o.last    = fin;
          if (fin) begin
            state_d = S_IDLE;
          end else begin
            cur_d           = next_idx(cur_q);
            ram_req_o.rd_en = 1'b1;
            ram_req_o.addr  = cur_d;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      cur_q   <= '0;
      empty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cur_q   <= cur_d;
      empty_q <= empty_d;
    end
  end

endmodule

FILE: design/circular_fifo_queue_top.sv
// Enqueue and any empty/full result appear in the cycle after the transfer;
// dequeue and peek pass the single-port entry store read register first.
// Enqueue: one item per cycle while m_axis_tready is high. Dequeue/peek/display
// hold the input until done; display sends N entries, one per ready cycle.
// Reset: asynchronous, active low; queue empty, pointers at 0, no result pending.
module circular_fifo_queue_top import cfq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] data_in
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] data_out, [32] is_empty, [33] is_full
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast
);

  ram_req_t ram_req;
  res_t     res;
  word_t    rdata;
  logic     out_free;

  logic     out_valid_q, out_valid_d;
  status_e  status_q;
  word_t    data_q;
  logic     last_q, is_empty_q, is_full_q;

  assign out_free = !out_valid_q || m_axis_tready;

  cfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (opcode_e'(s_axis_tuser)),
    .data_in_i  (word_t'(s_axis_tdata)),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .ram_req_o  (ram_req),
    .res_o      (res)
  );

  cfq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      status_q   <= res.status;
      data_q     <= res.use_ram ? rdata : '0;
      last_q     <= res.last;
      is_empty_q <= res.is_empty;
      is_full_q  <= res.is_full;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, is_full_q, is_empty_q, data_q};
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = last_q;

endmodule

FILE: design/cfq_checker.sv
// Port-level checks for circular_fifo_queue_top, attached by bind.
// Depends on circular_fifo_queue_top_assert.svh and cfq_pkg.
`include "circular_fifo_queue_top_assert.svh"

module cfq_checker import cfq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic stall;
  logic empty_res;
  logic full_res;
  logic data_zero;
  assign stall     = m_axis_tvalid && !m_axis_tready;
  assign empty_res = m_axis_tvalid && (m_axis_tuser == ST_EMPTY);
  assign full_res  = m_axis_tvalid && (m_axis_tuser == ST_FULL);
  assign data_zero = (m_axis_tdata[31:0] == '0);

  `CFQ_ASSERT_NXT(a_valid_holds, stall, m_axis_tvalid)
  `CFQ_ASSERT_NXT(a_payload_holds, stall, $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `CFQ_ASSERT_IMP(a_flags_excl, m_axis_tvalid, !(m_axis_tdata[32] && m_axis_tdata[33]))
  `CFQ_ASSERT_IMP(a_empty_result, empty_res, m_axis_tdata[32] && data_zero && m_axis_tlast)
  `CFQ_ASSERT_IMP(a_full_result, full_res, m_axis_tdata[33] && data_zero && m_axis_tlast)

endmodule

bind circular_fifo_queue_top cfq_checker u_cfq_checker (.*);
